>>> rtl/core/olwd_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list with delete by value: shared definitions
// Field widths, request codes and the control word that steers each cell.
// ----------------------------------------------------------------------------
package olwd_pkg;

   localparam int unsigned ACTION_WIDTH = 2;
   localparam int unsigned VALUE_WIDTH  = 32;
   localparam int unsigned LIMIT_WIDTH  = 5;
   localparam int unsigned COUNT_WIDTH  = 5;

   localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_BACK  = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_PUSH_FRONT = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_DELETE     = 2'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_POP_FRONT  = 2'd3;

   typedef struct packed {
      logic load;
      logic take_left;
      logic take_right;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_PASS = 2'b10
   } state_type;

endpackage

>>> rtl/core/olwd_cell.sv
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one entry and takes a new word, its left neighbour or its right
// neighbour as steered by the control word.
// ----------------------------------------------------------------------------
module olwd_cell #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  olwd_pkg::cell_ctrl_type ctrl,
   input  logic [DATA_WIDTH-1:0]  load_data,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic [DATA_WIDTH-1:0]  right_data,
   output logic [DATA_WIDTH-1:0]  data
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load) begin
         data_in = load_data;
      end else if (ctrl.take_left) begin
         data_in = left_data;
      end else if (ctrl.take_right) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> rtl/core/ordered_list_with_delete_by_value_core.sv
// ----------------------------------------------------------------------------
// Ordered list with delete by value
// A bounded double-ended list of words held in a row of cells, with push at
// either end, pop at the front and removal of the first matches of a value.
// ----------------------------------------------------------------------------
// A request is transferred at a rising edge with start high and busy low.
// Every request gives exactly one result, marked by rsp_valid for one cycle;
// the receiver must take it then, as results cannot be held off.
// Push back, push front and pop front are handled on transfer: the result is
// shown in the cycle after the transfer and busy stays low, so one such
// request may be transferred in every cycle.
// A delete passes every held entry once through the front cell, one entry
// per cycle, while the cells rotate towards the front; a match within the
// limit is dropped and any other entry goes back in at the tail. Busy is
// high until every held entry has passed, and the result is shown in the cycle
// after the last of them; on an empty list a delete answers in the next cycle
// like a push.
// The front, back, count and empty ports always show the current list; they
// belong to a result in the cycle that rsp_valid marks.
// Reset empties the list and clears the sequencer; the cells need no reset.
// ----------------------------------------------------------------------------
module ordered_list_with_delete_by_value_core #(
   parameter int unsigned CAPACITY   = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [olwd_pkg::ACTION_WIDTH-1:0]      req_action,
   input  logic [olwd_pkg::VALUE_WIDTH-1:0]       req_value,
   input  logic [olwd_pkg::LIMIT_WIDTH-1:0]       req_delete_limit,
   output logic                                   rsp_valid,
   output logic [olwd_pkg::VALUE_WIDTH-1:0]       rsp_front_word,
   output logic [olwd_pkg::VALUE_WIDTH-1:0]       rsp_back_word,
   output logic [olwd_pkg::COUNT_WIDTH-1:0]       rsp_entry_count,
   output logic                                   rsp_list_empty,
   output logic [olwd_pkg::COUNT_WIDTH-1:0]       rsp_removed_count,
   output logic [olwd_pkg::VALUE_WIDTH-1:0]       rsp_popped_word,
   output logic                                   rsp_overflow
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W =
      (CNT_W > olwd_pkg::LIMIT_WIDTH) ? CNT_W : olwd_pkg::LIMIT_WIDTH;

   olwd_pkg::state_type                 state_ff, state_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [CNT_W-1:0]                    steps_ff, steps_in;
   logic [CNT_W-1:0]                    removed_ff, removed_in;
   logic [DATA_WIDTH-1:0]               match_ff, match_in;
   logic [olwd_pkg::LIMIT_WIDTH-1:0]    limit_ff, limit_in;
   logic [DATA_WIDTH-1:0]               back_ff, back_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [olwd_pkg::COUNT_WIDTH-1:0]    rsp_removed_ff, rsp_removed_in;
   logic [olwd_pkg::VALUE_WIDTH-1:0]    rsp_popped_ff, rsp_popped_in;
   logic                                rsp_overflow_ff, rsp_overflow_in;

   logic                    accept;
   logic                    full;
   logic                    in_pass;
   logic                    drop;
   logic [DATA_WIDTH-1:0]   word_in;
   logic [DATA_WIDTH-1:0]   front;
   logic [DATA_WIDTH-1:0]   load_word;
   logic                    do_push_back;
   logic                    do_push_front;
   logic                    do_pop;
   logic                    do_keep;
   logic                    do_rotate;

   logic [DATA_WIDTH-1:0]   cell_data [CAPACITY];
   olwd_pkg::cell_ctrl_type cell_ctrl [CAPACITY];

   assign accept  = start && !busy;
   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign in_pass = (state_ff == olwd_pkg::ST_PASS);
   assign word_in = DATA_WIDTH'(req_value);
   assign front   = cell_data[0];
   assign drop    = (front == match_ff) && (CMP_W'(removed_ff) < CMP_W'(limit_ff));

   assign do_push_back  = accept && (req_action == olwd_pkg::ACT_PUSH_BACK) && !full;
   assign do_push_front = accept && (req_action == olwd_pkg::ACT_PUSH_FRONT) && !full;
   assign do_pop        = accept && (req_action == olwd_pkg::ACT_POP_FRONT) &&
                          (count_ff != '0);
   assign do_rotate     = in_pass;
   assign do_keep       = in_pass && !drop;
   assign load_word     = in_pass ? front : word_in;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      always_comb begin
         cell_ctrl[i].load       = (do_push_back && (count_ff == CNT_W'(i))) ||
                                   (do_push_front && (i == 0)) ||
                                   (do_keep && (count_ff == CNT_W'(i + 1)));
         cell_ctrl[i].take_left  = do_push_front;
         cell_ctrl[i].take_right = do_pop || do_rotate;
      end

      olwd_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .load_data  (load_word),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      steps_in        = steps_ff;
      removed_in      = removed_ff;
      match_in        = match_ff;
      limit_in        = limit_ff;
      back_in         = back_ff;
      rsp_valid_in    = 1'b0;
      rsp_removed_in  = rsp_removed_ff;
      rsp_popped_in   = rsp_popped_ff;
      rsp_overflow_in = rsp_overflow_ff;

      unique case (state_ff)
         olwd_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_removed_in  = '0;
               rsp_popped_in   = '0;
               rsp_overflow_in = 1'b0;
               case (req_action)
                  olwd_pkg::ACT_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_overflow_in = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                        back_in  = word_in;
                     end
                  end
                  olwd_pkg::ACT_PUSH_FRONT: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_overflow_in = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                        if (count_ff == '0) begin
                           back_in = word_in;
                        end
                     end
                  end
                  olwd_pkg::ACT_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in   = olwd_pkg::ST_PASS;
                        steps_in   = count_ff;
                        removed_in = '0;
                        match_in   = word_in;
                        limit_in   = req_delete_limit;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff != '0) begin
                        count_in       = count_ff - 1'b1;
                        rsp_removed_in = olwd_pkg::COUNT_WIDTH'(1);
                        rsp_popped_in  = olwd_pkg::VALUE_WIDTH'(front);
                     end
                  end
               endcase
            end
         end
         olwd_pkg::ST_PASS: begin
            if (drop) begin
               count_in   = count_ff - 1'b1;
               removed_in = removed_ff + 1'b1;
            end else begin
               back_in = front;
            end
            steps_in = steps_ff - 1'b1;
            if (steps_ff == CNT_W'(1)) begin
               state_in       = olwd_pkg::ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_removed_in = olwd_pkg::COUNT_WIDTH'(removed_in);
            end
         end
         default: begin
            state_in = olwd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= olwd_pkg::ST_IDLE;
         count_ff        <= '0;
         steps_ff        <= '0;
         removed_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
         rsp_removed_ff  <= '0;
         rsp_popped_ff   <= '0;
         rsp_overflow_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         steps_ff        <= steps_in;
         removed_ff      <= removed_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_removed_ff  <= rsp_removed_in;
         rsp_popped_ff   <= rsp_popped_in;
         rsp_overflow_ff <= rsp_overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      limit_ff <= limit_in;
      back_ff  <= back_in;
   end

   assign busy              = in_pass;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_front_word    = (count_ff != '0) ? olwd_pkg::VALUE_WIDTH'(front) : '0;
   assign rsp_back_word     = (count_ff != '0) ? olwd_pkg::VALUE_WIDTH'(back_ff) : '0;
   assign rsp_entry_count   = olwd_pkg::COUNT_WIDTH'(count_ff);
   assign rsp_list_empty    = (count_ff == '0);
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_popped_word   = rsp_popped_ff;
   assign rsp_overflow      = rsp_overflow_ff;

`ifndef SYNTH
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_single_cycle_result: assert property (@(posedge clock) disable iff (reset)
      accept && (req_action != olwd_pkg::ACT_DELETE) |=> rsp_valid_ff && !busy)
      else $error("push or pop gave no result in the next cycle");

   a_pass_never_grows: assert property (@(posedge clock) disable iff (reset)
      in_pass |=> count_ff <= $past(count_ff))
      else $error("list grew during a delete pass");

   a_overflow_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_overflow_ff |-> full && (rsp_removed_ff == '0))
      else $error("overflow reported while list not full");

   a_pass_removed_bounded: assert property (@(posedge clock) disable iff (reset)
      in_pass |-> CMP_W'(removed_ff) <= CMP_W'(limit_ff))
      else $error("delete removed more entries than its limit");
`endif

endmodule
